// ----- rtl/core/double_ended_queue_ring_macros.svh -----
// Assertion macros of the double-ended queue checker.
`ifndef DOUBLE_ENDED_QUEUE_RING_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_RING_MACROS_SVH

// Checked on every rising clock edge once reset is released.
`define DEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, during reset as well.
`define DEQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/dequ_pkg.sv -----
// Shared constants, codes and types of the double-ended queue.
package dequ_pkg;

  // Default sizes of the storage.
  localparam int unsigned CAPACITY_DEF   = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed widths of the request and response fields.
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_READ       = 3'd4,
    CMD_WRITE      = 3'd5,
    CMD_INSERT     = 3'd6,
    CMD_ERASE      = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ADDR,
    S_SHIFT,
    S_INS_LAST,
    S_RESP
  } state_e;

endpackage

// ----- rtl/core/dequ_if.sv -----
// Request and response channel interfaces of the double-ended queue.
interface dequ_req_if
  import dequ_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   position;

  modport source (output valid, output command, output value, output position, input ready);
  modport sink   (input valid, input command, input value, input position, output ready);
endinterface

interface dequ_rsp_if
  import dequ_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  read_data;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output read_data, output occupancy, input ready);
  modport sink   (input valid, input status, input read_data, input occupancy, output ready);
endinterface

// ----- rtl/core/double_ended_queue_ring.sv -----
// Sequence: each request is checked first; push, pop front, read and write then pass an address
// state before the result state, while pop back and any rejected request go straight to the result.
// Insert and erase also move elements one at a time in a shift state; insert ends with a last write.
// One request at a time: the next is taken in the cycle after the result register is loaded.
// The shared ring address adder and the store's separate read and write ports set this sequence.
// Reset clears the front pointer, the element count and the result valid; no store sweep.
module double_ended_queue_ring
  import dequ_pkg::*;
#(
  parameter int unsigned Capacity  = CAPACITY_DEF,
  parameter int unsigned DataWidth = DATA_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dequ_req_if.sink   req_i,
  dequ_rsp_if.source rsp_o
);

  localparam int unsigned PW = $clog2(Capacity);

  logic                 mem_we;
  logic [PW-1:0]        mem_waddr;
  logic [DataWidth-1:0] mem_wdata;
  logic                 mem_re;
  logic [PW-1:0]        mem_raddr;
  logic [DataWidth-1:0] mem_rdata;

  // Sequencer with the shared slot unit.
  dequ_ctrl #(
    .Capacity (Capacity),
    .DataWidth(DataWidth)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  // Element store.
  dequ_ram #(
    .Capacity (Capacity),
    .DataWidth(DataWidth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

// ----- rtl/core/dequ_slot_unit.sv -----
// Shared ring address unit: physical slot of a logical offset from the front.
module dequ_slot_unit
  import dequ_pkg::*;
#(
  parameter int unsigned Capacity = CAPACITY_DEF
) (
  input  logic [$clog2(Capacity)-1:0] base_i,
  input  logic [$clog2(Capacity)-1:0] offset_i,
  output logic [$clog2(Capacity)-1:0] slot_o
);

  localparam int unsigned PW = $clog2(Capacity);
  localparam logic [PW:0] CapL = (PW+1)'(Capacity);

  logic [PW:0] sum;

  // Both operands stay below the capacity, so one conditional subtract wraps the sum.
  always_comb begin
    sum = {1'b0, base_i} + {1'b0, offset_i};
    if (sum >= CapL) begin
      sum = sum - CapL;
    end
    slot_o = sum[PW-1:0];
  end

endmodule

// ----- rtl/core/dequ_ram.sv -----
// Element store: one write port and one read port with registered read data.
module dequ_ram
  import dequ_pkg::*;
#(
  parameter int unsigned Capacity  = CAPACITY_DEF,
  parameter int unsigned DataWidth = DATA_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(Capacity)-1:0] waddr_i,
  input  logic [DataWidth-1:0]        wdata_i,
  input  logic                        re_i,
  input  logic [$clog2(Capacity)-1:0] raddr_i,
  output logic [DataWidth-1:0]        rdata_o
);

  logic [DataWidth-1:0] mem_q [Capacity];
  logic [DataWidth-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/dequ_ctrl.sv -----
// Command sequencer: checks, pointer updates and element moves through the shared slot unit.
module dequ_ctrl
  import dequ_pkg::*;
#(
  parameter int unsigned Capacity  = CAPACITY_DEF,
  parameter int unsigned DataWidth = DATA_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dequ_req_if.sink                    req_i,
  dequ_rsp_if.source                  rsp_o,
  output logic                        mem_we_o,
  output logic [$clog2(Capacity)-1:0] mem_waddr_o,
  output logic [DataWidth-1:0]        mem_wdata_o,
  output logic                        mem_re_o,
  output logic [$clog2(Capacity)-1:0] mem_raddr_o,
  input  logic [DataWidth-1:0]        mem_rdata_i
);

  localparam int unsigned PW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CapCount = CW'(Capacity);
  localparam logic [PW-1:0] OffsetPrev = PW'(Capacity - 1);
  localparam logic [PW-1:0] OffsetNext = PW'(1);

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [PW-1:0]        front_q, front_d;
  logic [PW-1:0]        idx_q, idx_d;
  logic [PW-1:0]        last_q, last_d;
  logic [PW-1:0]        dst_q, dst_d;
  logic [PW-1:0]        src_q, src_d;
  logic                 more_q, more_d;
  logic                 pend_q, pend_d;
  status_e              status_q, status_d;
  logic                 rsp_valid_q, rsp_valid_d;

  cmd_e                 cmd_q;
  logic [DataWidth-1:0] val_q;
  logic [POS_W-1:0]     pos_q;
  status_e              rsp_status_q;
  logic [VALUE_W-1:0]   rsp_data_q;
  logic [OCC_W-1:0]     rsp_occ_q;

  logic                 accept;
  logic                 rsp_load;
  status_e              check_status;
  logic [PW-1:0]        slot;
  logic [PW-1:0]        pos_p;
  logic [PW-1:0]        count_m1;
  logic [XW-1:0]        pos_x;
  logic [XW-1:0]        count_x;
  logic                 full;
  logic                 empty;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // Shared slot unit; every memory address and front update goes through it.
  dequ_slot_unit #(
    .Capacity(Capacity)
  ) u_slot (
    .base_i  (front_q),
    .offset_i(idx_q),
    .slot_o  (slot)
  );

  assign pos_p    = PW'(pos_q);
  assign count_m1 = PW'(count_q - CW'(1));
  assign pos_x    = XW'(pos_q);
  assign count_x  = XW'(count_q);
  assign full     = (count_q == CapCount);
  assign empty    = (count_q == '0);

  // Legality check of the latched request.
  always_comb begin
    check_status = STAT_DONE;
    case (cmd_q)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (full) check_status = STAT_FULL;
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (empty) check_status = STAT_EMPTY;
      end
      CMD_INSERT: begin
        if (pos_x > count_x) begin
          check_status = STAT_RANGE;
        end else if (full) begin
          check_status = STAT_FULL;
        end
      end
      default: begin
        if (pos_x >= count_x) check_status = STAT_RANGE;
      end
    endcase
  end

  // Sequencer: next state, pointer updates and memory control.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    front_d     = front_q;
    idx_d       = idx_q;
    last_d      = last_q;
    dst_d       = dst_q;
    src_d       = src_q;
    more_d      = more_q;
    pend_d      = pend_q;
    status_d    = status_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_load    = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = slot;
    mem_wdata_o = val_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = slot;

    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_CHECK;
      end

      S_CHECK: begin
        status_d = check_status;
        if (check_status != STAT_DONE) begin
          state_d = S_RESP;
        end else begin
          state_d = S_ADDR;
          case (cmd_q)
            CMD_PUSH_BACK:  idx_d = count_m1 + PW'(1);
            CMD_PUSH_FRONT: idx_d = OffsetPrev;
            CMD_POP_BACK: begin
              count_d = count_q - CW'(1);
              state_d = S_RESP;
            end
            CMD_POP_FRONT:  idx_d = OffsetNext;
            CMD_INSERT:     idx_d = count_m1 + PW'(1);
            default:        idx_d = pos_p;
          endcase
        end
      end

      S_ADDR: begin
        state_d = S_RESP;
        case (cmd_q)
          CMD_PUSH_BACK: begin
            mem_we_o = 1'b1;
            count_d  = count_q + CW'(1);
          end
          CMD_PUSH_FRONT: begin
            mem_we_o = 1'b1;
            front_d  = slot;
            count_d  = count_q + CW'(1);
          end
          CMD_POP_FRONT: begin
            front_d = slot;
            count_d = count_q - CW'(1);
          end
          CMD_READ:  mem_re_o = 1'b1;
          CMD_WRITE: mem_we_o = 1'b1;
          CMD_INSERT: begin
            // Elements from the back down to the index move one slot back.
            dst_d   = slot;
            more_d  = (idx_q != pos_p);
            idx_d   = idx_q - PW'(1);
            last_d  = pos_p;
            pend_d  = 1'b0;
            state_d = S_SHIFT;
          end
          default: begin
            // Erase: elements after the index move one slot forward.
            dst_d   = slot;
            more_d  = (pos_p != count_m1);
            idx_d   = pos_p + PW'(1);
            last_d  = count_m1;
            pend_d  = 1'b0;
            state_d = S_SHIFT;
          end
        endcase
      end

      S_SHIFT: begin
        // Write back the element read in the previous cycle.
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = dst_q;
          mem_wdata_o = mem_rdata_i;
          dst_d       = src_q;
        end
        // Read the next element to move, one per cycle.
        if (more_q) begin
          mem_re_o = 1'b1;
          src_d    = slot;
          pend_d   = 1'b1;
          if (idx_q == last_q) begin
            more_d = 1'b0;
          end else if (cmd_q == CMD_INSERT) begin
            idx_d = idx_q - PW'(1);
          end else begin
            idx_d = idx_q + PW'(1);
          end
        end else begin
          pend_d = 1'b0;
          if (cmd_q == CMD_INSERT) begin
            state_d = S_INS_LAST;
          end else begin
            count_d = count_q - CW'(1);
            state_d = S_RESP;
          end
        end
      end

      S_INS_LAST: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = dst_q;
        count_d     = count_q + CW'(1);
        state_d     = S_RESP;
      end

      S_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load    = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      front_q     <= '0;
      more_q      <= 1'b0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      front_q     <= front_d;
      more_q      <= more_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Working registers of the command in progress.
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    last_q   <= last_d;
    dst_q    <= dst_d;
    src_q    <= src_d;
    status_q <= status_d;
    if (accept) begin
      cmd_q <= cmd_e'(req_i.command);
      val_q <= DataWidth'(req_i.value);
      pos_q <= req_i.position;
    end
  end

  // Response register.
  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_status_q <= status_q;
      rsp_occ_q    <= OCC_W'(count_q);
      if ((cmd_q == CMD_READ) && (status_q == STAT_DONE)) begin
        rsp_data_q <= VALUE_W'(mem_rdata_i);
      end else begin
        rsp_data_q <= '0;
      end
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.read_data = rsp_data_q;
  assign rsp_o.occupancy = rsp_occ_q;

endmodule

// ----- rtl/core/dequ_checker.sv -----
// Port-level assertions of the double-ended queue and their binding to the top level.
`include "double_ended_queue_ring_macros.svh"

module dequ_checker
  import dequ_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] rsp_status_i,
  input logic [VALUE_W-1:0]  rsp_read_data_i,
  input logic [OCC_W-1:0]    rsp_occupancy_i
);

  // No result is shown while reset is held.
  `DEQ_ASSERT_ALWAYS(a_no_rsp_in_reset, !rst_ni |-> !rsp_valid_i, "result valid during reset")

  // A result that is not taken stays unchanged.
  `DEQ_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_read_data_i) && $stable(rsp_occupancy_i), "result changed while stalled")

  // A request is worked on alone: the block is busy in the cycle after taking one.
  `DEQ_ASSERT(a_busy_after_req, req_valid_i && req_ready_i |=> !req_ready_i, "ready right after a request")

  // An empty report always comes with zero occupancy.
  `DEQ_ASSERT(a_empty_count, rsp_valid_i && (rsp_status_i == STAT_EMPTY) |-> (rsp_occupancy_i == '0), "empty status with elements held")

  // Failed commands return no data.
  `DEQ_ASSERT(a_fail_no_data, rsp_valid_i && (rsp_status_i != STAT_DONE) |-> (rsp_read_data_i == '0), "data returned on a failed command")

endmodule

bind double_ended_queue_ring dequ_checker u_dequ_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_status_i   (rsp_o.status),
  .rsp_read_data_i(rsp_o.read_data),
  .rsp_occupancy_i(rsp_o.occupancy)
);

// ----- bench/tb_top.sv -----
// Testbench for the ring-held double-ended queue: directed and random requests checked against a behavioral predictor.
module tb_top;
  import dequ_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [VALUE_W-1:0] STORE_MASK =
    (DATA_WIDTH_DEF >= VALUE_W) ? '1 : VALUE_W'((64'd1 << DATA_WIDTH_DEF) - 1);

  typedef struct {
    cmd_e             cmd;
    status_e          status;
    logic [VALUE_W-1:0] read_data;
    logic [OCC_W-1:0] occupancy;
  } deque_result_t;

  logic clk;
  logic rst_n;

  dequ_req_if req_if ();
  dequ_rsp_if rsp_if ();

  double_ended_queue_ring DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Predicted contents of the ring, its front slot and its element count.
  logic [VALUE_W-1:0] ring_mem [CAPACITY_DEF];
  int unsigned        head_slot;
  int unsigned        fill_count;

  // Results still owed by the queue, oldest first.
  deque_result_t pending_results[$];

  bit          gaps_off;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned responses_seen;
  int unsigned cmd_tally [8];
  int unsigned status_tally [4];
  int unsigned peak_fill;

  // Free-running clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Physical slot of the element at a logical index from the front.
  function automatic int unsigned ring_slot(int unsigned idx);
    return (head_slot + idx) % CAPACITY_DEF;
  endfunction

  // Applies one request to the predicted queue and returns the expected response.
  function automatic deque_result_t predict_deque_command(cmd_e cmd, logic [VALUE_W-1:0] data,
                                                          logic [POS_W-1:0] position);
    deque_result_t r;
    int unsigned   k;
    int unsigned   p;
    p = position;
    r.cmd = cmd;
    r.status = STAT_DONE;
    r.read_data = '0;
    data = data & STORE_MASK;
    case (cmd)
      CMD_PUSH_BACK: begin
        if (fill_count >= CAPACITY_DEF) r.status = STAT_FULL;
        else begin
          ring_mem[ring_slot(fill_count)] = data;
          fill_count++;
        end
      end
      CMD_PUSH_FRONT: begin
        if (fill_count >= CAPACITY_DEF) r.status = STAT_FULL;
        else begin
          head_slot = (head_slot == 0) ? CAPACITY_DEF - 1 : head_slot - 1;
          ring_mem[head_slot] = data;
          fill_count++;
        end
      end
      CMD_POP_BACK: begin
        if (fill_count == 0) r.status = STAT_EMPTY;
        else fill_count--;
      end
      CMD_POP_FRONT: begin
        if (fill_count == 0) r.status = STAT_EMPTY;
        else begin
          head_slot = ring_slot(1);
          fill_count--;
        end
      end
      CMD_READ: begin
        if (p >= fill_count) r.status = STAT_RANGE;
        else r.read_data = ring_mem[ring_slot(p)];
      end
      CMD_WRITE: begin
        if (p >= fill_count) r.status = STAT_RANGE;
        else ring_mem[ring_slot(p)] = data;
      end
      CMD_INSERT: begin
        // The position is checked before fullness.
        if (p > fill_count) r.status = STAT_RANGE;
        else if (fill_count >= CAPACITY_DEF) r.status = STAT_FULL;
        else begin
          for (k = fill_count; k > p; k--) ring_mem[ring_slot(k)] = ring_mem[ring_slot(k - 1)];
          ring_mem[ring_slot(p)] = data;
          fill_count++;
        end
      end
      default: begin
        if (p >= fill_count) r.status = STAT_RANGE;
        else begin
          for (k = p; k + 1 < fill_count; k++) ring_mem[ring_slot(k)] = ring_mem[ring_slot(k + 1)];
          fill_count--;
        end
      end
    endcase
    r.occupancy = OCC_W'(fill_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
    $display("MISMATCH at response %0d: %s, got 0x%0h, expected 0x%0h", responses_seen, what, got,
             want);
    mismatches++;
  endtask

  // Drives one request, waits for it to be taken and records what it should return.
  task automatic send_request(cmd_e cmd, logic [VALUE_W-1:0] data, logic [POS_W-1:0] position);
    deque_result_t want;
    int unsigned   gap;
    if (!gaps_off && $urandom_range(99) < 26) begin
      gap = $urandom_range(4, 1);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.command  <= cmd;
    req_if.value    <= data;
    req_if.position <= position;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    want = predict_deque_command(cmd, data, position);
    pending_results.insert(pending_results.size(), want);
    cmd_tally[cmd]++;
    status_tally[want.status]++;
    if (fill_count > peak_fill) peak_fill = fill_count;
  endtask

  // Holds off the sender until every outstanding response has come back.
  task automatic wait_for_all_results();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Picks a position, mostly valid for the current count, sometimes out of range.
  function automatic logic [POS_W-1:0] pick_position(cmd_e cmd, bit near_end);
    int unsigned limit;
    int unsigned r;
    int unsigned span;
    limit = (cmd == CMD_INSERT) ? fill_count + 1 : fill_count;
    r = $urandom_range(99);
    if (limit == 0 || r < 8) return POS_W'($urandom_range(2047, limit));
    if (r < 12) return POS_W'(limit);
    if (near_end) begin
      // Positions near the back keep the element moves short on a large queue.
      span = (limit < 8) ? limit : 8;
      return POS_W'(limit - 1 - $urandom_range(span - 1, 0));
    end
    return POS_W'($urandom_range(limit - 1, 0));
  endfunction

  // Random commands that keep the count roughly between lo and hi.
  task automatic run_random_commands(int unsigned count, int unsigned lo, int unsigned hi,
                                     bit near_end);
    cmd_e        cmd;
    bit          grows;
    bit          shrinks;
    int unsigned i;
    for (i = 0; i < count; i++) begin
      // A stretch in the middle runs with no idle cycles on either side.
      gaps_off = (count >= 150) && (i >= count / 3) && (i < count / 3 + count / 4);
      cmd = cmd_e'($urandom_range(7));
      grows = (cmd == CMD_PUSH_BACK) || (cmd == CMD_PUSH_FRONT) || (cmd == CMD_INSERT);
      shrinks = (cmd == CMD_POP_BACK) || (cmd == CMD_POP_FRONT) || (cmd == CMD_ERASE);
      if (fill_count < lo && shrinks && $urandom_range(99) < 70) begin
        case ($urandom_range(2))
          0:       cmd = CMD_PUSH_BACK;
          1:       cmd = CMD_PUSH_FRONT;
          default: cmd = CMD_INSERT;
        endcase
      end else if (fill_count > hi && grows && $urandom_range(99) < 70) begin
        case ($urandom_range(2))
          0:       cmd = CMD_POP_BACK;
          1:       cmd = CMD_POP_FRONT;
          default: cmd = CMD_ERASE;
        endcase
      end
      send_request(cmd, $urandom, pick_position(cmd, near_end));
    end
    gaps_off = 1'b0;
  endtask

  // Empty-queue rejections, extreme values and positions, and each command on a short queue.
  task automatic test_directed_edges();
    send_request(CMD_POP_BACK, '0, '0);
    send_request(CMD_POP_FRONT, '0, '0);
    send_request(CMD_READ, '0, '0);
    send_request(CMD_WRITE, 32'h1234_5678, '0);
    send_request(CMD_ERASE, '0, '0);
    send_request(CMD_INSERT, 32'hDEAD_BEEF, 11'd1);
    send_request(CMD_INSERT, 32'h0000_0001, 11'd0);
    send_request(CMD_PUSH_BACK, 32'hFFFF_FFFF, '0);
    send_request(CMD_PUSH_FRONT, 32'h0000_0000, '0);
    send_request(CMD_READ, '0, 11'd0);
    send_request(CMD_READ, '0, 11'd1);
    send_request(CMD_READ, '0, 11'd2);
    send_request(CMD_WRITE, 32'hA5A5_5A5A, 11'd1);
    send_request(CMD_INSERT, 32'h5A5A_A5A5, 11'd1);
    // Insert at the count behaves as a push at the back.
    send_request(CMD_INSERT, 32'h8000_0000, 11'd4);
    send_request(CMD_READ, '0, 11'd5);
    send_request(CMD_READ, '0, 11'd2047);
    send_request(CMD_INSERT, 32'h7FFF_FFFF, 11'd2047);
    send_request(CMD_ERASE, '0, 11'd0);
    send_request(CMD_ERASE, '0, 11'd3);
    send_request(CMD_READ, '0, 11'd1);
    send_request(CMD_POP_BACK, '0, '0);
    send_request(CMD_POP_FRONT, '0, '0);
    send_request(CMD_POP_FRONT, '0, '0);
    send_request(CMD_ERASE, '0, 11'd1024);
  endtask

  // Fills the ring to capacity, checks rejections when full, works near full and drains.
  task automatic test_capacity_limits();
    while (fill_count < CAPACITY_DEF)
      send_request(cmd_e'($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK), $urandom, '0);
    send_request(CMD_PUSH_BACK, $urandom, '0);
    send_request(CMD_PUSH_FRONT, $urandom, '0);
    send_request(CMD_INSERT, $urandom, 11'd0);
    send_request(CMD_INSERT, $urandom, 11'd1024);
    send_request(CMD_INSERT, $urandom, 11'd1025);
    send_request(CMD_READ, '0, 11'd1023);
    send_request(CMD_READ, '0, 11'd1024);
    send_request(CMD_WRITE, $urandom, 11'd1023);
    // Long element moves across the whole ring.
    send_request(CMD_ERASE, '0, 11'd0);
    send_request(CMD_INSERT, $urandom, 11'd0);
    send_request(CMD_ERASE, '0, 11'd1023);
    send_request(CMD_POP_FRONT, '0, '0);
    run_random_commands(60, CAPACITY_DEF - 8, CAPACITY_DEF, 1'b1);
    while (fill_count > 0)
      send_request(cmd_e'($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK), '0, '0);
    send_request(CMD_POP_BACK, '0, '0);
  endtask

  // Mixed traffic over short and medium queue lengths.
  task automatic test_random_traffic();
    run_random_commands(150, 0, 6, 1'b0);
    run_random_commands(150, 12, 64, 1'b0);
  endtask

  // Compares each response taken with the oldest expectation and stalls at random.
  always @(posedge clk) begin : response_checker
    deque_result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      responses_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("response with no request outstanding", rsp_if.occupancy, '0);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (rsp_if.status !== want.status)
          report_mismatch({want.cmd.name(), " status"}, rsp_if.status, want.status);
        if (rsp_if.read_data !== want.read_data)
          report_mismatch({want.cmd.name(), " read data"}, rsp_if.read_data, want.read_data);
        if (rsp_if.occupancy !== want.occupancy)
          report_mismatch({want.cmd.name(), " occupancy"}, rsp_if.occupancy, want.occupancy);
      end
    end
    rsp_if.ready <= gaps_off || ($urandom_range(99) >= 26);
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Test completed with failures");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.command  = CMD_PUSH_BACK;
    req_if.value    = '0;
    req_if.position = '0;
    rsp_if.ready    = 1'b0;
    gaps_off        = 1'b0;
    head_slot       = 0;
    fill_count      = 0;
    peak_fill       = 0;
    mismatches      = 0;
    responses_seen  = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    wait_for_all_results();
    test_capacity_limits();
    wait_for_all_results();
    test_random_traffic();
    wait_for_all_results();
    repeat (40) @(posedge clk);

    $display("Ran %0d requests, %0d inserts and %0d erases among them, peak occupancy %0d of %0d.",
             responses_seen, cmd_tally[CMD_INSERT], cmd_tally[CMD_ERASE], peak_fill,
             CAPACITY_DEF);
    $display("Rejections seen: %0d out of range, %0d empty, %0d full; %0d cycles in all.",
             status_tally[STAT_RANGE], status_tally[STAT_EMPTY], status_tally[STAT_FULL],
             cycle_count);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/dequ_pkg.sv
rtl/core/dequ_if.sv
rtl/core/dequ_slot_unit.sv
rtl/core/dequ_ram.sv
rtl/core/dequ_ctrl.sv
rtl/core/double_ended_queue_ring.sv
rtl/core/dequ_checker.sv
bench/tb_top.sv
